### hdl/hrba_pkg.sv
// Shared types, constants and keycode tables for the HID report barcode assembler.
// Used by hrba_key_dec and hid_report_barcode_assembler; depends on nothing else.

package hrba_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int BUF_DEPTH_DEF       = 32;
    localparam int KEYS_PER_REPORT_DEF = 6;

    // Fixed field widths of the words.
    localparam int KEY_SLOTS   = 6;
    localparam int KEY_SLOT_W  = 3;
    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 6;
    localparam int MIN_LEN_W   = 6;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd4;

    // Keycodes and characters.
    localparam logic [7:0] SHIFT_MASK = 8'h22;
    localparam logic [7:0] KEY_A      = 8'h04;
    localparam logic [7:0] KEY_Z      = 8'h1D;
    localparam logic [7:0] KEY_1      = 8'h1E;
    localparam logic [7:0] KEY_0      = 8'h27;
    localparam logic [7:0] KEY_ENTER  = 8'h28;
    localparam logic [7:0] KEY_SPACE  = 8'h2C;
    localparam logic [7:0] KEY_COMMA  = 8'h36;
    localparam logic [7:0] KEY_PERIOD = 8'h37;
    localparam logic [7:0] KEY_SLASH  = 8'h38;

    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

    // Digit row, plain and shifted, in keycode order 1..9 then 0.
    localparam logic [CHAR_W-1:0] DIGIT_PLAIN [10] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
    };
    localparam logic [CHAR_W-1:0] DIGIT_SHIFT [10] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
    };

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    // What one keycode means.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CHAR,
        KIND_ENTER
    } t_key_kind;

    typedef struct packed {
        t_key_kind         kind;
        logic [CHAR_W-1:0] ch;
    } t_key_dec;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYS,
        ST_STATUS,
        ST_TAKE_RD,
        ST_TAKE_LD
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] modifier;
        logic [7:0] key0;
        logic [7:0] key1;
        logic [7:0] key2;
        logic [7:0] key3;
        logic [7:0] key4;
        logic [7:0] key5;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic               last;
        logic               ready_res;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               empty_res;
    } t_out_word;

endpackage

### hdl/hrba_key_dec.sv
// Keycode decoder: turns one HID keycode and the shift state into a character or Enter.
// Depends on hrba_pkg for the keycode constants and digit tables.

module hrba_key_dec (
    input  logic              i_shift,
    input  logic [7:0]        i_key,
    output hrba_pkg::t_key_dec o_dec
);
    import hrba_pkg::*;

    logic [7:0] w_letter_off;
    logic [7:0] w_digit_off;

    assign w_letter_off = i_key - KEY_A;
    assign w_digit_off  = i_key - KEY_1;

    // Letters by offset, digits through the tables, the rest by keycode.
    always_comb begin
        o_dec.kind = KIND_NONE;
        o_dec.ch   = '0;
        if (i_key inside {[KEY_A:KEY_Z]}) begin
            o_dec.kind = KIND_CHAR;
            o_dec.ch   = (i_shift ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(w_letter_off);
        end else if (i_key inside {[KEY_1:KEY_0]}) begin
            o_dec.kind = KIND_CHAR;
            o_dec.ch   = i_shift ? DIGIT_SHIFT[w_digit_off[3:0]] : DIGIT_PLAIN[w_digit_off[3:0]];
        end else begin
            case (i_key)
                KEY_ENTER: begin
                    o_dec.kind = KIND_ENTER;
                end
                KEY_SPACE: begin
                    o_dec.kind = KIND_CHAR;
                    o_dec.ch   = ASCII_SPACE;
                end
                KEY_COMMA: begin
                    o_dec.kind = KIND_CHAR;
                    o_dec.ch   = i_shift ? 7'h3C : 7'h2C;
                end
                KEY_PERIOD: begin
                    o_dec.kind = KIND_CHAR;
                    o_dec.ch   = i_shift ? 7'h3E : 7'h2E;
                end
                KEY_SLASH: begin
                    o_dec.kind = KIND_CHAR;
                    o_dec.ch   = i_shift ? 7'h3F : 7'h2F;
                end
                default: begin
                    o_dec.kind = KIND_NONE;
                end
            endcase
        end
    end

endmodule

### hdl/hid_report_barcode_assembler.sv
// Top level of the HID report barcode assembler: sequencer, code buffer memory, output register.
// Depends on hrba_pkg and hrba_key_dec.
//
//   channel  | direction | handshake                     | word
//   ---------+-----------+-------------------------------+-----------------------
//   in       | into      | i_in_valid / o_in_stall       | i_in_word  (t_in_word)
//   out      | out of    | o_out_valid / i_out_stall     | o_out_word (t_out_word)
//   cfg      | into      | i_cfg_valid / o_cfg_ready     | i_cfg_data (min length)
//
// A keyboard report is handled one keycode slot per cycle: the slot is decoded and a
// character is appended to the buffer memory while there is room; then the status word is loaded.
// A take reads each kept character through the buffer memory's registered read port
// (ST_TAKE_RD, then ST_TAKE_LD into the output register); flush, empty take and unknown
// operations load only the status word. Reset is synchronous and clears the count, flags
// and min length (to 4), not the buffer memory; a stalled output word holds and the sequencer waits.

module hid_report_barcode_assembler #(
    parameter int BUF_DEPTH       = hrba_pkg::BUF_DEPTH_DEF,
    parameter int KEYS_PER_REPORT = hrba_pkg::KEYS_PER_REPORT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  hrba_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output hrba_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hrba_pkg::MIN_LEN_W-1:0]     i_cfg_data
);
    import hrba_pkg::*;

    localparam int AW   = $clog2(BUF_DEPTH);
    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int CMPW = (CW > MIN_LEN_W) ? CW : MIN_LEN_W;

    // Control registers.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_ready, n_ready;
    logic                  r_ovf, n_ovf;
    logic                  r_have_ns, n_have_ns;
    logic                  r_empty, n_empty;
    logic [KEY_SLOT_W-1:0] r_slot, n_slot;
    logic                  r_out_valid, n_out_valid;
    logic [MIN_LEN_W-1:0]  r_min_len;

    // Payload registers.
    logic [AW-1:0]         r_first_ns, n_first_ns;
    logic [AW-1:0]         r_last_ns, n_last_ns;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_hi, n_hi;
    logic                  r_shift, n_shift;
    logic [7:0]            r_keys [KEY_SLOTS];
    t_out_word             r_out, n_out;

    // Buffer memory.
    logic [CHAR_W-1:0]     r_mem [BUF_DEPTH];
    logic [CHAR_W-1:0]     r_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [CHAR_W-1:0]     w_wr_data;
    logic                  w_rd_en;

    logic                  w_in_acc;
    logic                  w_out_free;
    t_key_dec              w_dec;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    // Decode of the keycode slot under the slot counter.
    hrba_key_dec u_key_dec (
        .i_shift (r_shift),
        .i_key   (r_keys[r_slot]),
        .o_dec   (w_dec)
    );

    // The code buffer: one write port for appends, one registered read port for takes.
    // Appends and reads happen in different states, so the same entry never overlaps.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_ovf       <= 1'b0;
            r_have_ns   <= 1'b0;
            r_empty     <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_min_len   <= MIN_LEN_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ready     <= n_ready;
            r_ovf       <= n_ovf;
            r_have_ns   <= n_have_ns;
            r_empty     <= n_empty;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_len <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_first_ns <= n_first_ns;
        r_last_ns  <= n_last_ns;
        r_ptr      <= n_ptr;
        r_hi       <= n_hi;
        r_shift    <= n_shift;
        r_out      <= n_out;
        if (w_in_acc) begin
            r_keys[0] <= i_in_word.key0;
            r_keys[1] <= i_in_word.key1;
            r_keys[2] <= i_in_word.key2;
            r_keys[3] <= i_in_word.key3;
            r_keys[4] <= i_in_word.key4;
            r_keys[5] <= i_in_word.key5;
        end
    end

    // Sequencer: next state, buffer accesses and the output register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ready     = r_ready;
        n_ovf       = r_ovf;
        n_have_ns   = r_have_ns;
        n_empty     = r_empty;
        n_slot      = r_slot;
        n_first_ns  = r_first_ns;
        n_last_ns   = r_last_ns;
        n_ptr       = r_ptr;
        n_hi        = r_hi;
        n_shift     = r_shift;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[AW-1:0];
        w_wr_data   = w_dec.ch;
        w_rd_en     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_empty = 1'b0;
                    n_shift = (i_in_word.modifier & SHIFT_MASK) != 8'h00;
                    n_slot  = '0;
                    case (i_in_word.operation)
                        OP_REPORT: begin
                            n_state = ST_KEYS;
                        end
                        OP_TAKE: begin
                            // Trim bounds are tracked while appending; take only reads.
                            n_count   = '0;
                            n_ready   = 1'b0;
                            n_ovf     = 1'b0;
                            n_have_ns = 1'b0;
                            n_ptr     = r_first_ns;
                            n_hi      = r_last_ns;
                            if (r_have_ns) begin
                                n_state = ST_TAKE_RD;
                            end else begin
                                n_empty = 1'b1;
                                n_state = ST_STATUS;
                            end
                        end
                        OP_FLUSH: begin
                            n_count   = '0;
                            n_ready   = 1'b0;
                            n_ovf     = 1'b0;
                            n_have_ns = 1'b0;
                            n_state   = ST_STATUS;
                        end
                        default: begin
                            n_state = ST_STATUS;
                        end
                    endcase
                end
            end

            ST_KEYS: begin
                // One keycode slot per cycle.
                case (w_dec.kind)
                    KIND_ENTER: begin
                        if (CMPW'(r_count) >= CMPW'(r_min_len)) begin
                            n_ready = 1'b1;
                        end
                    end
                    KIND_CHAR: begin
                        if (r_count < CW'(BUF_DEPTH)) begin
                            w_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                            if (w_dec.ch != ASCII_SPACE) begin
                                n_last_ns = r_count[AW-1:0];
                                n_have_ns = 1'b1;
                                if (!r_have_ns) begin
                                    n_first_ns = r_count[AW-1:0];
                                end
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_slot == KEY_SLOT_W'(KEYS_PER_REPORT - 1)) begin
                    n_state = ST_STATUS;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end

            ST_STATUS: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.char_code = '0;
                    n_out.last      = 1'b1;
                    n_out.ready_res = r_ready;
                    n_out.count     = COUNT_W'(r_count);
                    n_out.overflow  = r_ovf;
                    n_out.empty_res = r_empty;
                    n_state         = ST_IDLE;
                end
            end

            ST_TAKE_RD: begin
                // Read only when the output register will be free for the data.
                if (w_out_free) begin
                    w_rd_en = 1'b1;
                    n_state = ST_TAKE_LD;
                end
            end

            ST_TAKE_LD: begin
                n_out_valid     = 1'b1;
                n_out.char_code = r_rd_data;
                n_out.last      = (r_ptr == r_hi);
                n_out.ready_res = r_ready;
                n_out.count     = COUNT_W'(r_count);
                n_out.overflow  = r_ovf;
                n_out.empty_res = 1'b0;
                if (r_ptr == r_hi) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = ST_TAKE_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never passes the buffer depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUF_DEPTH))
        else $error("buffer count exceeds depth");

    // A take leaves the buffer and both flags cleared.
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.operation == OP_TAKE) |=> (r_count == '0 && !r_ready && !r_ovf))
        else $error("take did not clear the buffer state");

    // The read pointer stays within the trimmed range while characters are read out.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAKE_RD || r_state == ST_TAKE_LD) |-> r_ptr <= r_hi)
        else $error("take read pointer passed the trimmed end");

    // An empty take result carries no character and closes the run.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.empty_res) |-> (o_out_word.char_code == '0 && o_out_word.last))
        else $error("empty take word carries a character");
`endif

endmodule
